// ===== hdl/acr_pkg.sv =====
// Shared types and constants for the allpass/comb reverberator.
package acr_pkg;

  localparam int NUM_LINES = 9;
  localparam int LINE_W    = 4;
  localparam int HEAD_W    = 11;
  localparam int MEM_AW    = 13;
  localparam int MEM_WORDS = 6908;
  localparam int CFG_AW    = 3;

  localparam int LINE_DEPTH [NUM_LINES] = '{225, 341, 441, 1116, 1356, 1422, 1617, 211, 179};
  localparam int LINE_BASE  [NUM_LINES] = '{0, 225, 566, 1007, 2123, 3479, 4901, 6518, 6729};

  localparam logic [LINE_W-1:0] LINE_AP0   = 4'd0;
  localparam logic [LINE_W-1:0] LINE_COMB0 = 4'd3;
  localparam logic [LINE_W-1:0] LINE_DEC0  = 4'd7;

  localparam logic [CFG_AW-1:0] REG_WET = 3'd0;
  localparam logic [CFG_AW-1:0] REG_APG = 3'd1;
  localparam logic [CFG_AW-1:0] REG_CG0 = 3'd2;
  localparam logic [CFG_AW-1:0] REG_CG1 = 3'd3;
  localparam logic [CFG_AW-1:0] REG_CG2 = 3'd4;
  localparam logic [CFG_AW-1:0] REG_CG3 = 3'd5;

  typedef enum logic [2:0] {A_RDATA, A_MR, A_W, A_LP, A_DRY, A_DL} asel_t;
  typedef enum logic [2:0] {B_APG, B_COMB, B_LPIN, B_LPFB, B_DRYW, B_WET} bsel_t;
  typedef enum logic [1:0] {WS_W, WS_V, WS_S} wsel_t;

  typedef struct packed {
    logic              clr;
    logic              ld_in;
    logic              rd;
    logic              wr;
    wsel_t             wsel;
    logic              adv;
    logic [LINE_W-1:0] line;
    logic [1:0]        unit;
    logic              side;
    asel_t             asel;
    bsel_t             bsel;
    logic              wide;
    logic              ld_t;
    logic              ld_w;
    logic              ld_x;
    logic              ld_acc;
    logic              ld_lp;
    logic              ld_sum;
    logic              ld_dl;
    logic              ld_macc;
    logic              ld_side;
    logic              ld_out;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic out_free;
  } stat_t;

endpackage

// ===== hdl/allpass_comb_reverb.sv =====
// Top level of the stereo allpass/comb reverberator.
// Input channel: in_valid/in_stall with one stereo pair (in_left_in, in_right_in)
// per transaction. Output channel: out_valid/out_stall with one mixed stereo pair
// per input transaction, in order. Configuration: cfg_we/cfg_addr/cfg_wdata,
// to be written by the user only while the block is idle, which the block
// does not enforce; unknown indexes are ignored. Each pair is processed by one
// shared multiplier: the three allpass sections, the four combs, then the two
// output taps and mix, plus one step each for accept and output hand-off. The
// single delay memory (6908 words) and the multiplier serialize this work.
// After reset the delay memory is swept to zero, one word per cycle, over all
// 6908 words; in_stall stays high during the sweep.
// The result sits in an output register; the next pair is accepted while it
// waits. If the receiver keeps out_stall high, the following result waits in
// the final step until the register is free.
module allpass_comb_reverb #(
  parameter int SAMPLE_BITS    = 16,
  parameter int STATE_BITS     = 32,
  parameter int COEF_FRAC_BITS = 15
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_left_in,
  input  logic signed [SAMPLE_BITS-1:0] in_right_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_left_out,
  output logic signed [SAMPLE_BITS-1:0] out_right_out,
  input  logic                          cfg_we,
  input  logic [acr_pkg::CFG_AW-1:0]    cfg_addr,
  input  logic [COEF_FRAC_BITS:0]       cfg_wdata
);
  import acr_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  acr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  acr_dp #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .STATE_BITS     (STATE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_left_in    (in_left_in),
    .in_right_in   (in_right_in),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_left_out  (out_left_out),
    .out_right_out (out_right_out)
  );

endmodule

// ===== hdl/acr_ctrl.sv =====
// Sequencer for the reverberator: steps the shared datapath through each stage.
module acr_ctrl (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  acr_pkg::stat_t stat,
  output logic         in_stall,
  output acr_pkg::cmd_t  cmd
);
  import acr_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_AP    = 3'd2;
  localparam logic [2:0] ST_COMB  = 3'd3;
  localparam logic [2:0] ST_DEC   = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [3:0] step_r, step_nxt;
  logic [1:0] unit_r, unit_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      step_r  <= '0;
      unit_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      unit_r  <= unit_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unit_nxt  = unit_r;
    cmd       = '0;
    cmd.unit  = unit_r;
    cmd.side  = unit_r[0];
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.ld_in = 1'b1;
          state_nxt = ST_AP;
          step_nxt  = '0;
          unit_nxt  = '0;
        end
      end
      ST_AP: begin
        cmd.line = LINE_AP0 + LINE_W'(unit_r);
        cmd.asel = A_RDATA;
        cmd.bsel = B_APG;
        unique case (step_r)
          4'd0: cmd.rd = 1'b1;
          4'd1: cmd.ld_t = 1'b1;
          4'd3: begin
            cmd.wr   = 1'b1;
            cmd.wsel = WS_W;
            cmd.ld_w = 1'b1;
          end
          4'd4: cmd.asel = A_W;
          4'd6: begin
            cmd.ld_x = 1'b1;
            cmd.adv  = 1'b1;
          end
          default: ;
        endcase
        step_nxt = step_r + 4'd1;
        if (step_r == 4'd6) begin
          step_nxt = '0;
          if (unit_r == 2'd2) begin
            state_nxt = ST_COMB;
            unit_nxt  = '0;
          end else begin
            unit_nxt = unit_r + 2'd1;
          end
        end
      end
      ST_COMB: begin
        cmd.line = LINE_COMB0 + LINE_W'(unit_r);
        cmd.asel = A_RDATA;
        cmd.bsel = B_COMB;
        unique case (step_r)
          4'd0: cmd.rd = 1'b1;
          4'd3: begin
            cmd.asel = A_MR;
            cmd.bsel = B_LPIN;
          end
          4'd5: begin
            cmd.ld_acc = 1'b1;
            cmd.asel   = A_LP;
            cmd.bsel   = B_LPFB;
          end
          4'd7: cmd.ld_lp = 1'b1;
          4'd8: begin
            cmd.wr     = 1'b1;
            cmd.wsel   = WS_V;
            cmd.ld_sum = 1'b1;
            cmd.adv    = 1'b1;
          end
          default: ;
        endcase
        step_nxt = step_r + 4'd1;
        if (step_r == 4'd8) begin
          step_nxt = '0;
          if (unit_r == 2'd3) begin
            state_nxt = ST_DEC;
            unit_nxt  = '0;
          end else begin
            unit_nxt = unit_r + 2'd1;
          end
        end
      end
      ST_DEC: begin
        cmd.line = LINE_DEC0 + LINE_W'(unit_r);
        cmd.asel = A_DRY;
        cmd.bsel = B_DRYW;
        unique case (step_r)
          4'd0: begin
            cmd.wr   = 1'b1;
            cmd.wsel = WS_S;
            cmd.adv  = 1'b1;
          end
          4'd1: cmd.rd = 1'b1;
          4'd2: cmd.ld_dl = 1'b1;
          4'd4: begin
            cmd.ld_macc = 1'b1;
            cmd.asel    = A_DL;
            cmd.bsel    = B_WET;
          end
          4'd5: cmd.wide = 1'b1;
          4'd6: cmd.ld_side = 1'b1;
          default: ;
        endcase
        step_nxt = step_r + 4'd1;
        if (step_r == 4'd6) begin
          step_nxt = '0;
          if (unit_r == 2'd1) begin
            state_nxt = ST_FIN;
            unit_nxt  = '0;
          end else begin
            unit_nxt = unit_r + 2'd1;
          end
        end
      end
      ST_FIN: begin
        if (stat.out_free) begin
          cmd.ld_out = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule

// ===== hdl/acr_dp.sv =====
// Datapath: delay-line memory, shared multiplier, filter state and output register.
module acr_dp #(
  parameter int SAMPLE_BITS    = 16,
  parameter int STATE_BITS     = 32,
  parameter int COEF_FRAC_BITS = 15
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  acr_pkg::cmd_t                     cmd,
  output acr_pkg::stat_t                    stat,
  input  logic signed [SAMPLE_BITS-1:0]     in_left_in,
  input  logic signed [SAMPLE_BITS-1:0]     in_right_in,
  input  logic                              cfg_we,
  input  logic [acr_pkg::CFG_AW-1:0]        cfg_addr,
  input  logic [COEF_FRAC_BITS:0]           cfg_wdata,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic signed [SAMPLE_BITS-1:0]     out_left_out,
  output logic signed [SAMPLE_BITS-1:0]     out_right_out
);
  import acr_pkg::*;

  localparam int F   = COEF_FRAC_BITS;
  localparam int SW  = STATE_BITS;
  localparam int CW  = F + 2;
  localparam int AW  = (SW > SAMPLE_BITS + 8) ? SW : SAMPLE_BITS + 8;
  localparam int PW  = AW + CW;
  localparam int LPIN    = (8 * (2 ** F) + 5) / 10;
  localparam int LPFB    = (2 * (2 ** F) + 5) / 10;
  localparam int APG_RST = (7 * (2 ** F) + 5) / 10;

  localparam logic signed [PW:0] SMAX = {{(PW-SW+2){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [PW:0] SMIN = ~SMAX;
  localparam logic signed [PW:0] QMAX = {{(PW-SAMPLE_BITS+2){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [PW:0] QMIN = ~QMAX;
  localparam logic signed [CW-1:0] ONE = {2'b01, {F{1'b0}}};

  function automatic logic signed [SW-1:0] sat_st(input logic signed [PW:0] v);
    sat_st = (v > SMAX) ? SMAX[SW-1:0] : ((v < SMIN) ? SMIN[SW-1:0] : v[SW-1:0]);
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_smp(input logic signed [PW:0] v);
    sat_smp = (v > QMAX) ? QMAX[SAMPLE_BITS-1:0] :
              ((v < QMIN) ? QMIN[SAMPLE_BITS-1:0] : v[SAMPLE_BITS-1:0]);
  endfunction

  // configuration
  logic [F:0]   wet_r;
  logic [F-1:0] apg_r;
  logic [F-1:0] cg_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wet_r <= '0;
      apg_r <= F'(APG_RST);
      for (int i = 0; i < 4; i++) cg_r[i] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_WET: wet_r    <= cfg_wdata;
        REG_APG: apg_r    <= cfg_wdata[F-1:0];
        REG_CG0: cg_r[0]  <= cfg_wdata[F-1:0];
        REG_CG1: cg_r[1]  <= cfg_wdata[F-1:0];
        REG_CG2: cg_r[2]  <= cfg_wdata[F-1:0];
        REG_CG3: cg_r[3]  <= cfg_wdata[F-1:0];
        default: ;
      endcase
    end
  end

  logic signed [SAMPLE_BITS-1:0] l_r, r_r, lo_r, ro_r, dry;
  logic signed [SW-1:0] x_r, t_r, w_r, acc_r, dl_r, rdata_r;
  logic signed [SW-1:0] lp_r [4];
  logic signed [SW+1:0] sum_r;
  logic signed [PW-1:0] prod_r, rnd_r, macc_r, half;
  logic signed [AW-1:0] a_mux;
  logic signed [CW-1:0] b_mux, wet_s;
  logic signed [SW-1:0] mr, w_val, x_new, lp_val, v_val, s_val, x_in, wdata;
  logic signed [PW:0]   mix_y;
  logic signed [SAMPLE_BITS-1:0] smp;
  logic [HEAD_W-1:0]    heads_r [NUM_LINES];
  logic [MEM_AW-1:0]    clr_cnt_r, mem_addr, waddr;
  logic                 mem_we;
  logic signed [SW-1:0] mem [MEM_WORDS];
  logic                 out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_left_r, out_right_r;

  assign mr     = sat_st((PW+1)'(rnd_r));
  assign w_val  = sat_st((PW+1)'(mr) + (PW+1)'(x_r));
  assign x_new  = sat_st((PW+1)'(t_r) - (PW+1)'(mr));
  assign lp_val = sat_st((PW+1)'(acc_r) + (PW+1)'(mr));
  assign v_val  = sat_st((PW+1)'(x_r) + (PW+1)'(lp_r[cmd.unit]));
  assign s_val  = sat_st((PW+1)'(sum_r));
  assign x_in   = sat_st(((PW+1)'(in_left_in) + (PW+1)'(in_right_in)) <<< 7);
  assign mix_y  = ((PW+1)'(macc_r) + (PW+1)'(rnd_r) + (PW+1)'(128)) >>> 8;
  assign smp    = sat_smp(mix_y);
  assign dry    = cmd.side ? r_r : l_r;
  assign wet_s  = CW'($signed({1'b0, wet_r}));

  always_comb begin
    unique case (cmd.asel)
      A_RDATA: a_mux = AW'(rdata_r);
      A_MR:    a_mux = AW'(mr);
      A_W:     a_mux = AW'(w_r);
      A_LP:    a_mux = AW'(lp_r[cmd.unit]);
      A_DRY:   a_mux = AW'(dry) <<< 8;
      A_DL:    a_mux = AW'(dl_r);
      default: a_mux = '0;
    endcase
    unique case (cmd.bsel)
      B_APG:   b_mux = CW'($signed({1'b0, apg_r}));
      B_COMB:  b_mux = CW'($signed({1'b0, cg_r[cmd.unit]}));
      B_LPIN:  b_mux = CW'(LPIN);
      B_LPFB:  b_mux = CW'(LPFB);
      B_DRYW:  b_mux = ONE - wet_s;
      B_WET:   b_mux = wet_s;
      default: b_mux = '0;
    endcase
    unique case (cmd.wsel)
      WS_W:    wdata = w_val;
      WS_V:    wdata = v_val;
      WS_S:    wdata = s_val;
      default: wdata = '0;
    endcase
  end

  assign half = cmd.wide ? (PW'(1) <<< F) : (PW'(1) <<< (F - 1));

  always_ff @(posedge clk) begin
    prod_r <= a_mux * b_mux;
    if (cmd.wide) rnd_r <= (prod_r + half) >>> (F + 1);
    else          rnd_r <= (prod_r + half) >>> F;
  end

  // delay-line memory, all nine lines back to back
  assign mem_addr = MEM_AW'(LINE_BASE[cmd.line]) + MEM_AW'(heads_r[cmd.line]);
  assign waddr    = cmd.clr ? clr_cnt_r : mem_addr;
  assign mem_we   = cmd.clr || cmd.wr;

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= cmd.clr ? '0 : wdata;
    if (cmd.rd) rdata_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr && !stat.clr_done) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LINES; i++) heads_r[i] <= '0;
      for (int i = 0; i < 4; i++) lp_r[i] <= '0;
    end else begin
      if (cmd.adv) begin
        if (heads_r[cmd.line] == HEAD_W'(LINE_DEPTH[cmd.line] - 1)) heads_r[cmd.line] <= '0;
        else heads_r[cmd.line] <= heads_r[cmd.line] + 1'b1;
      end
      if (cmd.ld_lp) lp_r[cmd.unit] <= lp_val;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      l_r   <= in_left_in;
      r_r   <= in_right_in;
      x_r   <= x_in;
      sum_r <= '0;
    end
    if (cmd.ld_t)    t_r    <= rdata_r;
    if (cmd.ld_w)    w_r    <= w_val;
    if (cmd.ld_x)    x_r    <= x_new;
    if (cmd.ld_acc)  acc_r  <= mr;
    if (cmd.ld_sum)  sum_r  <= sum_r + (SW+2)'(v_val);
    if (cmd.ld_dl)   dl_r   <= rdata_r;
    if (cmd.ld_macc) macc_r <= rnd_r;
    if (cmd.ld_side) begin
      if (cmd.side) ro_r <= smp;
      else          lo_r <= smp;
    end
    if (cmd.ld_out) begin
      out_left_r  <= lo_r;
      out_right_r <= ro_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.ld_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign stat.clr_done  = (clr_cnt_r == MEM_AW'(MEM_WORDS - 1));
  assign stat.out_free  = !out_valid_r || !out_stall;
  assign out_valid      = out_valid_r;
  assign out_left_out   = out_left_r;
  assign out_right_out  = out_right_r;

endmodule

// ===== hdl/acr_checker.sv =====
// Port-level checks for the reverberator, bound to the top level.
module acr_port_checks #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [SAMPLE_BITS-1:0] out_left_out,
  input logic [SAMPLE_BITS-1:0] out_right_out
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction taken while one is in flight");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without processing");

  a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_left_out) && $stable(out_right_out))
    else $error("stalled output transaction changed");

endmodule

bind allpass_comb_reverb acr_port_checks #(.SAMPLE_BITS(SAMPLE_BITS)) u_acr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_left_out  (out_left_out),
  .out_right_out (out_right_out)
);
